// ===== sv/assert_macros.svh =====
// Assertion helpers for the knn_chk checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/knn_pkg.sv =====
package knn_pkg;

  localparam int MAX_ENTRIES  = 64;
  localparam int DIM          = 16;
  localparam int MAX_TOP_K    = 16;
  localparam int ELEMENT_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int POS_W  = $clog2(DIM + 2);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int K_W    = $clog2(MAX_TOP_K + 1);
  localparam int DIST_W = 38;
  localparam int SUM_W  = DIST_W + 1;
  localparam int SQ_W   = 2 * (ELEMENT_BITS + 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DIM      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef logic [DIM-1:0][ELEMENT_BITS-1:0] vec_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [31:0]             key;
    logic [ELEMENT_BITS-1:0] elem;
    logic [DIM_W-1:0]        pos;
    logic                    srch;
    logic                    commit;
    logic                    remove;
    logic                    clear;
    logic [IDX_W-1:0]        slot;
    logic                    take;
    logic [IDX_W-1:0]        take_slot;
    logic                    clr_taken;
    logic [DIM_W-1:0]        gj;
    vec_t                    stage;
  } cmd_t;

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic              go;
    logic              found;
    logic [DIST_W-1:0] sq_dist;
    logic [31:0]       key;
    logic [IDX_W-1:0]  idx;
  } link_t;

endpackage

// ===== sv/knn_req_if.sv =====
interface knn_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] key;
  logic signed [15:0] element;
  logic        last;
  logic [4:0]  top_k;

  modport source (output valid, op, key, element, last, top_k, input ready);
  modport sink (input valid, op, key, element, last, top_k, output ready);
endinterface

// ===== sv/knn_rsp_if.sv =====
interface knn_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] key_res;
  logic [37:0] distance;
  logic signed [15:0] element_res;
  logic [3:0]  rank;
  logic [6:0]  live_count;
  logic        last_res;

  modport source (output valid, status, key_res, distance, element_res, rank, live_count,
                  last_res, input ready);
  modport sink (input valid, status, key_res, distance, element_res, rank, live_count,
                last_res, output ready);
endinterface

// ===== sv/knn_l2_table_search.sv =====
// Stream items (add and search elements) leave no result until the final one. Add,
// remove, clear and failed requests answer in the cycle after they are accepted.
// A search returns n hits; for each hit the scan token is launched, passes through the
// cell chain, is captured and is emitted. Get returns DIM elements, one per cycle while
// the output is not stalled. A new request item is taken only after the previous answer
// run is emitted. Synchronous reset empties the table; no clearing pass is needed.
module knn_l2_table_search import knn_pkg::*; (
  input logic      clk,
  input logic      rst,
  knn_req_if.sink  req,
  knn_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEL  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_GET  = 2'd3;

  logic [1:0]       state;
  logic [POS_W-1:0] pos;
  logic             is_srch;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] live;
  vec_t             stage;
  logic             scan_go;

  // Search and get sequencing.
  logic [K_W-1:0]    rk;
  logic [K_W-1:0]    n_hits;
  logic [DIST_W-1:0] best_dist;
  logic [31:0]       best_key;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  gslot;
  logic [DIM_W-1:0]  gj;
  logic [31:0]       gkey;

  // Output register.
  logic              ov;
  logic [2:0]        o_status;
  logic [31:0]       o_key;
  logic [DIST_W-1:0] o_dist;
  logic [ELEMENT_BITS-1:0] o_elem;
  logic [3:0]        o_rank;
  logic [CNT_W-1:0]  o_live;
  logic              o_last;

  cmd_t  cmd;
  link_t link [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES-1:0] del;
  logic [ELEMENT_BITS-1:0] cell_elem [MAX_ENTRIES];

  logic             acc;
  logic             out_free;
  logic             is_stream;
  logic             op_srch;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] count;
  logic             cnt_ok;
  logic             in_dim;
  logic             any_hit;
  logic             hit_del;
  logic [IDX_W-1:0] hit_idx;
  logic             has_room;
  logic             search_go;
  logic             last_hit;
  logic             start_scan;
  logic             load;
  logic [CNT_W-1:0] live_next;
  logic [K_W-1:0]   k_eff;
  logic [K_W-1:0]   n_calc;
  vec_t             stage_next;

  assign out_free  = !ov || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  assign is_stream = (req.op == OP_ADD) || (req.op == OP_SEARCH);
  assign op_srch   = (req.op == OP_SEARCH);
  // A change of stream kind restarts the stream.
  assign pos_eff   = (pos != '0 && is_srch != op_srch) ? '0 : pos;
  assign in_dim    = (pos_eff < POS_W'(DIM));
  assign count     = in_dim ? pos_eff + POS_W'(1) : POS_W'(DIM + 1);
  assign cnt_ok    = (count == POS_W'(DIM));
  assign has_room  = (fill < CNT_W'(MAX_ENTRIES));

  always_comb begin
    any_hit = |hit;
    hit_del = |(hit & del);
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  always_comb begin
    stage_next = stage;
    stage_next[pos_eff[DIM_W-1:0]] = req.element[ELEMENT_BITS-1:0];
  end

  // Clamp top_k into one to MAX_TOP_K, then to the live count.
  always_comb begin
    if (req.top_k == '0) k_eff = K_W'(1);
    else if (req.top_k > 5'(MAX_TOP_K)) k_eff = K_W'(MAX_TOP_K);
    else k_eff = K_W'(req.top_k);
    n_calc = (CNT_W'(k_eff) < live) ? k_eff : K_W'(live);
  end

  // Live count once the accepted item has taken effect.
  always_comb begin
    live_next = live;
    if (acc) begin
      if (is_stream && !op_srch && req.last && cnt_ok && (any_hit ? hit_del : has_room))
        live_next = live + CNT_W'(1);
      else if (req.op == OP_REMOVE && any_hit && !hit_del)
        live_next = live - CNT_W'(1);
      else if (req.op == OP_CLEAR)
        live_next = '0;
    end
  end

  assign search_go = acc && op_srch && req.last && fill != '0 && cnt_ok && live != '0;
  assign last_hit  = (rk + K_W'(1) == n_hits);
  assign start_scan = search_go || (state == S_EMIT && out_free && !last_hit);

  // Load the output register with a new result item.
  assign load = (state == S_IDLE) ?
                acc && ((is_stream && req.last && !search_go) || req.op == OP_REMOVE ||
                        req.op == OP_CLEAR || (req.op == OP_GET && !(any_hit && !hit_del))) :
                ((state == S_EMIT || state == S_GET) && out_free);

  always_comb begin
    cmd           = '0;
    cmd.key       = req.key;
    cmd.elem      = req.element[ELEMENT_BITS-1:0];
    cmd.pos       = pos_eff[DIM_W-1:0];
    cmd.stage     = stage_next;
    cmd.gj        = gj;
    cmd.srch      = acc && op_srch && in_dim;
    cmd.commit    = acc && req.op == OP_ADD && req.last && cnt_ok && (any_hit || has_room);
    cmd.remove    = acc && req.op == OP_REMOVE && any_hit;
    cmd.clear     = acc && req.op == OP_CLEAR;
    cmd.slot      = (req.op == OP_ADD && !any_hit) ? fill[IDX_W-1:0] : hit_idx;
    cmd.take      = (state == S_EMIT) && out_free;
    cmd.take_slot = best_idx;
    cmd.clr_taken = search_go;
  end

  // Launch the scan token in the cycle after start_scan, so the head cell already
  // sees its final distance and its updated taken mark.
  always_ff @(posedge clk) begin
    if (rst) scan_go <= 1'b0;
    else scan_go <= start_scan;
  end

  // Inject a fresh scan token at the head of the chain.
  always_comb begin
    link[0]       = '0;
    link[0].go    = scan_go;
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    knn_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(g)),
      .cmd     (cmd),
      .lin     (link[g]),
      .lout    (link[g+1]),
      .hit     (hit[g]),
      .del     (del[g]),
      .rd_elem (cell_elem[g])
    );
  end

  always_ff @(posedge clk) begin
    if (acc && is_stream && !op_srch && in_dim) stage <= stage_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ov      <= 1'b0;
      pos     <= '0;
      is_srch <= 1'b0;
      fill    <= '0;
      live    <= '0;
    end else begin
      if (load) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            // Defaults for a single-item answer.
            o_key  <= (op_srch || req.op == OP_CLEAR) ? '0 : req.key;
            o_dist <= '0;
            o_elem <= '0;
            o_rank <= '0;
            o_live <= live_next;
            o_last <= 1'b1;
            live   <= live_next;
            if (is_stream) begin
              is_srch <= op_srch;
              pos     <= req.last ? '0 : count;
              if (req.last && !op_srch) begin
                if (!cnt_ok) begin
                  o_status <= ST_DIM;
                end else if (!any_hit && !has_room) begin
                  o_status <= ST_FULL;
                end else begin
                  o_status <= ST_OK;
                  if (!any_hit) fill <= fill + CNT_W'(1);
                end
              end else if (req.last) begin
                if (search_go) begin
                  n_hits <= n_calc;
                  rk     <= '0;
                  state  <= S_SEL;
                end else begin
                  o_status <= (cnt_ok || fill == '0) ? ST_EMPTY : ST_DIM;
                end
              end
            end else if (req.op == OP_REMOVE) begin
              pos      <= '0;
              o_status <= any_hit ? ST_OK : ST_NOTFOUND;
            end else if (req.op == OP_GET) begin
              pos <= '0;
              if (any_hit && !hit_del) begin
                gslot <= hit_idx;
                gkey  <= req.key;
                gj    <= '0;
                state <= S_GET;
              end else begin
                o_status <= ST_NOTFOUND;
              end
            end else if (req.op == OP_CLEAR) begin
              pos      <= '0;
              fill     <= '0;
              o_status <= ST_OK;
            end
          end
        end
        S_SEL: begin
          // Hold until the token leaves the tail of the chain.
          if (link[MAX_ENTRIES].go) begin
            best_dist <= link[MAX_ENTRIES].sq_dist;
            best_key  <= link[MAX_ENTRIES].key;
            best_idx  <= link[MAX_ENTRIES].idx;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_status <= ST_OK;
            o_key    <= best_key;
            o_dist   <= best_dist;
            o_elem   <= '0;
            o_rank   <= rk[3:0];
            o_live   <= live;
            o_last   <= last_hit;
            rk       <= rk + K_W'(1);
            state    <= last_hit ? S_IDLE : S_SEL;
          end
        end
        S_GET: begin
          if (out_free) begin
            o_status <= ST_OK;
            o_key    <= gkey;
            o_dist   <= '0;
            o_elem   <= cell_elem[gslot];
            o_rank   <= 4'(gj);
            o_live   <= live;
            o_last   <= (gj == DIM_W'(DIM - 1));
            gj       <= gj + DIM_W'(1);
            if (gj == DIM_W'(DIM - 1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = ov;
  assign rsp.status      = o_status;
  assign rsp.key_res     = o_key;
  assign rsp.distance    = o_dist;
  assign rsp.element_res = o_elem;
  assign rsp.rank        = o_rank;
  assign rsp.live_count  = o_live;
  assign rsp.last_res    = o_last;

endmodule

// ===== sv/knn_cell.sv =====
module knn_cell import knn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IDX_W-1:0]        idx,
  input  cmd_t                    cmd,
  input  link_t                   lin,
  output link_t                   lout,
  output logic                    hit,
  output logic                    del,
  output logic [ELEMENT_BITS-1:0] rd_elem
);

  logic [31:0]       key;
  logic              used;
  logic              deleted;
  logic              taken;
  vec_t              vec;
  logic [DIST_W-1:0] pdist;

  logic signed [ELEMENT_BITS:0] diff;
  logic [SQ_W-1:0]              sq;
  logic [DIST_W-1:0]            base;
  logic [SUM_W-1:0]             sum;
  logic [DIST_W-1:0]            pdist_next;
  logic                         mine;
  logic                         ok;

  assign hit     = used && (key == cmd.key);
  assign del     = deleted;
  assign rd_elem = vec[cmd.gj];
  assign mine    = (cmd.slot == idx);
  assign ok      = used && !deleted && !taken;

  always_comb begin
    diff = $signed({cmd.elem[ELEMENT_BITS-1], cmd.elem})
         - $signed({vec[cmd.pos][ELEMENT_BITS-1], vec[cmd.pos]});
    sq   = SQ_W'(diff * diff);
    base = (cmd.pos == '0) ? '0 : pdist;
    sum  = {1'b0, base} + SUM_W'(sq);
    pdist_next = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      deleted <= 1'b0;
      taken   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        used    <= 1'b0;
        deleted <= 1'b0;
      end else if (cmd.commit && mine) begin
        used    <= 1'b1;
        deleted <= 1'b0;
      end else if (cmd.remove && mine) begin
        deleted <= 1'b1;
      end
      if (cmd.clr_taken) taken <= 1'b0;
      else if (cmd.take && cmd.take_slot == idx) taken <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mine) begin
      key <= cmd.key;
      vec <= cmd.stage;
    end
    if (cmd.srch) pdist <= pdist_next;
  end

  // Keep the smaller distance; on a tie the lower slot, seen first, stays.
  always_ff @(posedge clk) begin
    if (rst) begin
      lout.go <= 1'b0;
    end else begin
      lout.go <= lin.go;
    end
    if (ok && (!lin.found || pdist < lin.sq_dist)) begin
      lout.found   <= 1'b1;
      lout.sq_dist <= pdist;
      lout.key     <= key;
      lout.idx     <= idx;
    end else begin
      lout.found   <= lin.found;
      lout.sq_dist <= lin.sq_dist;
      lout.key     <= lin.key;
      lout.idx     <= lin.idx;
    end
  end

endmodule

// ===== sv/knn_chk.sv =====
`include "assert_macros.svh"

module knn_chk import knn_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [3:0] rank,
  input logic [6:0] live_count,
  input logic       last_res
);

  `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(rank))
  `CHK_IMP(a_status, out_valid, status <= ST_EMPTY)
  `CHK_IMP(a_err_single, out_valid && status != ST_OK, last_res && rank == 4'd0)
  `CHK_IMP(a_live, out_valid, live_count <= 7'(MAX_ENTRIES))

endmodule

bind knn_l2_table_search knn_chk u_knn_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .status     (rsp.status),
  .rank       (rsp.rank),
  .live_count (rsp.live_count),
  .last_res   (rsp.last_res)
);
